/* src/obb_pkg.sv */
// ----------------------------------------------------------------------------
// obb_pkg
// Shared constants and types for the oriented box ray slab intersector.
// ----------------------------------------------------------------------------
`default_nettype none

package obb_pkg;

  // default formats: Q12.8 coordinates, Q2.18 rotation entries
  localparam int unsigned COORD_WIDTH_DEF   = 20;
  localparam int unsigned ROT_FRAC_BITS_DEF = 18;

  // fraction bits of coordinates and ray parameters
  localparam int unsigned T_FRAC_BITS = 8;

  // configuration register map
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_EXTENTS = 3'd0,
    REG_ROT_ROW0     = 3'd1,
    REG_ROT_ROW1     = 3'd2,
    REG_ROT_ROW2     = 3'd3,
    REG_BOX_ORIGIN   = 3'd4
  } cfg_reg_e;

  // entry axis code, none when the ray starts inside every slab
  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X    = 2'd0;
  localparam axis_t AXIS_Y    = 2'd1;
  localparam axis_t AXIS_Z    = 2'd2;
  localparam axis_t AXIS_NONE = 2'd3;

endpackage

`default_nettype wire

/* src/obb_ray_slab_intersect.sv */
// ----------------------------------------------------------------------------
// obb_ray_slab_intersect
// Ray against oriented box, slab method in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer
//  ray in    start_x/y/z_i dir_x/y/z_i max_t_i        start_i high, busy_o low
//  result    hit_o entry_t_o normal_x/y/z_o           done_o high, one cycle
//  config    cfg_we_i cfg_idx_i cfg_wdata_i           cfg_we_i high
//
//  one ray per cycle while busy_o is low; each result comes out of the
//  rotate stages, the six bit-per-stage slab dividers, the clip register
//  and the result register. busy_o is high only in the first cycle after reset.
//  the result side cannot stall; rays in flight never wait or repeat.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_ray_slab_intersect
  import obb_pkg::*;
#(
  parameter int unsigned COORD_WIDTH   = obb_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ROT_FRAC_BITS = obb_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [COORD_WIDTH-1:0]   start_x_i,
  input  logic signed [COORD_WIDTH-1:0]   start_y_i,
  input  logic signed [COORD_WIDTH-1:0]   start_z_i,
  input  logic signed [COORD_WIDTH-1:0]   dir_x_i,
  input  logic signed [COORD_WIDTH-1:0]   dir_y_i,
  input  logic signed [COORD_WIDTH-1:0]   dir_z_i,
  input  logic [COORD_WIDTH-2:0]          max_t_i,
  output logic                            done_o,
  output logic                            hit_o,
  output logic [COORD_WIDTH-2:0]          entry_t_o,
  output logic signed [ROT_FRAC_BITS:0]   normal_x_o,
  output logic signed [ROT_FRAC_BITS:0]   normal_y_o,
  output logic signed [ROT_FRAC_BITS:0]   normal_z_o,
  input  logic                            cfg_we_i,
  input  logic [obb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [3*COORD_WIDTH-1:0]        cfg_wdata_i
);

  localparam int unsigned CW      = COORD_WIDTH;
  localparam int unsigned RF      = ROT_FRAC_BITS;
  localparam int unsigned T_W     = CW - 1;
  localparam int unsigned TS_W    = T_W + 2;
  localparam int unsigned L_W     = CW + 6;
  localparam int unsigned N_W     = L_W + 2;
  localparam int unsigned MAG_W   = N_W + T_FRAC_BITS;
  localparam int unsigned ROT_W   = RF + 2;
  localparam int unsigned FZ_W    = (ROT_W > CW) ? ROT_W : CW;
  localparam int unsigned NORM_W  = RF + 1;
  localparam int unsigned DIV_LAT = T_W + 1;
  localparam int unsigned LATENCY = T_W + 7;
  localparam logic signed [ROT_W:0] NMAX = (ROT_W+1)'((1 << RF) - 1);
  localparam logic signed [ROT_W:0] NMIN = -NMAX - (ROT_W+1)'(1);

  typedef struct packed {
    logic [T_W-1:0] max_t;
    logic [2:0]     zero;
    logic [2:0]     outside;
    logic [2:0]     neg_dir;
  } side_t;

  // configuration registers
  logic [3*CW-1:0] ext_q, org_q;
  logic [3*CW-1:0] rot_q [3];
  logic            busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q  <= '0;
      org_q  <= '0;
      rot_q  <= '{default: '0};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HALF_EXTENTS: ext_q    <= cfg_wdata_i;
        REG_ROT_ROW0:     rot_q[0] <= cfg_wdata_i;
        REG_ROT_ROW1:     rot_q[1] <= cfg_wdata_i;
        REG_ROT_ROW2:     rot_q[2] <= cfg_wdata_i;
        REG_BOX_ORIGIN:   org_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // held off for one cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end
  assign busy_o = busy_q;

  // box space transform
  logic signed [CW-1:0] start_v [3], dir_v [3];
  logic                 rv_valid;
  logic signed [L_W-1:0] lp [3], ld [3];
  logic [T_W-1:0]       rv_max_t;

  assign start_v = '{start_x_i, start_y_i, start_z_i};
  assign dir_v   = '{dir_x_i, dir_y_i, dir_z_i};

  obb_rotate #(.CW(CW), .RF(RF)) u_rotate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i && !busy_q),
    .start_i   (start_v),
    .dir_i     (dir_v),
    .max_t_i   (max_t_i),
    .origin_i  (org_q),
    .rot_row_i (rot_q),
    .valid_o   (rv_valid),
    .lp_o      (lp),
    .ld_o      (ld),
    .max_t_o   (rv_max_t)
  );

  // slab setup: numerators, divisor magnitude, flat-axis test
  logic [MAG_W-1:0] num_d [6];
  logic             neg_d [6];
  logic [L_W-1:0]   den_d [3];
  side_t            side_d;

  always_comb begin
    logic signed [N_W-1:0] e_s, ei, lps, n0, n1;
    logic [N_W-1:0]        m0, m1;
    side_d.max_t = rv_max_t;
    for (int i = 0; i < 3; i++) begin
      e_s = signed'(N_W'(ext_q[i*CW +: CW]));
      lps = N_W'(lp[i]);
      ei  = ld[i][L_W-1] ? -e_s : e_s;
      n0  = -(ei + lps);
      n1  = ei - lps;
      m0  = n0[N_W-1] ? unsigned'(-n0) : unsigned'(n0);
      m1  = n1[N_W-1] ? unsigned'(-n1) : unsigned'(n1);
      num_d[2*i]   = {m0, {T_FRAC_BITS{1'b0}}};
      num_d[2*i+1] = {m1, {T_FRAC_BITS{1'b0}}};
      neg_d[2*i]   = n0[N_W-1] ^ ld[i][L_W-1];
      neg_d[2*i+1] = n1[N_W-1] ^ ld[i][L_W-1];
      den_d[i]     = ld[i][L_W-1] ? unsigned'(-ld[i]) : unsigned'(ld[i]);
      side_d.zero[i]    = (ld[i] == '0);
      side_d.outside[i] = (lps < -e_s) || (lps > e_s);
      side_d.neg_dir[i] = ld[i][L_W-1];
    end
  end

  logic [MAG_W-1:0] num_q [6];
  logic             neg_q [6];
  logic [L_W-1:0]   den_q [3];
  side_t            side_q [DIV_LAT+1];
  logic             vld_q [DIV_LAT+1];

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    neg_q <= neg_d;
    den_q <= den_d;
    side_q[0] <= side_d;
    for (int k = 1; k <= DIV_LAT; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // valid bits alongside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '{default: 1'b0};
    end else begin
      vld_q[0] <= rv_valid;
      for (int k = 1; k <= DIV_LAT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // six slab dividers: entry and exit per axis
  logic signed [TS_W-1:0] tv [6];

  for (genvar j = 0; j < 6; j++) begin : g_div
    obb_div #(.NUM_W(MAG_W), .DEN_W(L_W), .Q_W(T_W)) u_div (
      .clk_i (clk_i),
      .num_i (num_q[j]),
      .den_i (den_q[j/2]),
      .neg_i (neg_q[j]),
      .t_o   (tv[j])
    );
  end

  // interval clipping over x, y, z
  logic                  ok_d, clip_neg_d;
  logic signed [TS_W-1:0] tmin_d;
  axis_t                 axis_d;

  always_comb begin
    logic signed [TS_W-1:0] tmax;
    side_t sd;
    sd         = side_q[DIV_LAT];
    ok_d       = 1'b1;
    tmin_d     = '0;
    tmax       = signed'(TS_W'(sd.max_t));
    axis_d     = AXIS_NONE;
    clip_neg_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (ok_d) begin
        if (sd.zero[i]) begin
          if (sd.outside[i]) ok_d = 1'b0;
        end else begin
          if (tv[2*i] > tmin_d) begin
            tmin_d     = tv[2*i];
            axis_d     = axis_t'(i);
            clip_neg_d = sd.neg_dir[i];
          end
          if (tv[2*i+1] < tmax) tmax = tv[2*i+1];
          if (tmin_d > tmax) ok_d = 1'b0;
        end
      end
    end
  end

  logic           clip_vld_q, clip_ok_q, clip_neg_q;
  logic [T_W-1:0] clip_t_q;
  axis_t          clip_axis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_vld_q <= 1'b0;
    end else begin
      clip_vld_q <= vld_q[DIV_LAT];
    end
  end

  always_ff @(posedge clk_i) begin
    clip_ok_q   <= ok_d;
    clip_t_q    <= tmin_d[T_W-1:0];
    clip_axis_q <= axis_d;
    clip_neg_q  <= clip_neg_d;
  end

  // world normal: rotation column of the entry axis, negated unless the ray runs negative, saturated
  logic signed [NORM_W-1:0] nrm_d [3];

  always_comb begin
    logic [FZ_W-1:0]        fz;
    logic signed [ROT_W-1:0] re;
    logic signed [ROT_W:0]   n;
    fz = '0;
    re = '0;
    n  = '0;
    for (int r = 0; r < 3; r++) begin
      case (clip_axis_q)
        AXIS_X:  fz = FZ_W'(rot_q[r][0 +: CW]);
        AXIS_Y:  fz = FZ_W'(rot_q[r][CW +: CW]);
        AXIS_Z:  fz = FZ_W'(rot_q[r][2*CW +: CW]);
        default: fz = '0;
      endcase
      re = signed'(fz[ROT_W-1:0]);
      n  = clip_neg_q ? (ROT_W+1)'(re) : -(ROT_W+1)'(re);
      if (n > NMAX) n = NMAX;
      if (n < NMIN) n = NMIN;
      nrm_d[r] = (clip_ok_q && clip_axis_q != AXIS_NONE) ? NORM_W'(n) : '0;
    end
  end

  // result registers
  logic                     done_q, hit_q;
  logic [T_W-1:0]           entry_t_q;
  logic signed [NORM_W-1:0] nrm_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= clip_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q     <= clip_ok_q;
    entry_t_q <= clip_ok_q ? clip_t_q : '0;
    nrm_q     <= nrm_d;
  end

  assign done_o     = done_q;
  assign hit_o      = hit_q;
  assign entry_t_o  = entry_t_q;
  assign normal_x_o = nrm_q[0];
  assign normal_y_o = nrm_q[1];
  assign normal_z_o = nrm_q[2];

`ifndef ASSERT_OFF
  // every accepted ray yields its result on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("result missing after accepted ray");

  // a miss reports zero parameter and zero normal
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_o |-> entry_t_o == '0 && normal_x_o == '0
      && normal_y_o == '0 && normal_z_o == '0)
    else $error("miss with nonzero payload");

  // a nonzero normal only comes with an entry strictly after the start
  a_normal_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_o && (normal_x_o != '0 || normal_y_o != '0 || normal_z_o != '0)
      |-> entry_t_o != '0)
    else $error("entry normal reported for ray starting inside");
`endif

endmodule

`default_nettype wire

/* src/obb_rotate.sv */
// ----------------------------------------------------------------------------
// obb_rotate
// Three stage box space transform: offset, products, sums with rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_rotate #(
  parameter int unsigned CW = 20,
  parameter int unsigned RF = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] start_i [3],
  input  logic signed [CW-1:0] dir_i [3],
  input  logic [CW-2:0]        max_t_i,
  input  logic [3*CW-1:0]      origin_i,
  input  logic [3*CW-1:0]      rot_row_i [3],
  output logic                 valid_o,
  output logic signed [CW+5:0] lp_o [3],
  output logic signed [CW+5:0] ld_o [3],
  output logic [CW-2:0]        max_t_o
);

  localparam int unsigned ROT_W  = RF + 2;
  localparam int unsigned FZ_W   = (ROT_W > CW) ? ROT_W : CW;
  localparam int unsigned REL_W  = CW + 1;
  localparam int unsigned PROD_W = ROT_W + REL_W;
  localparam int unsigned ACC_W  = PROD_W + 2;
  localparam int unsigned L_W    = CW + 6;
  localparam logic signed [ACC_W:0] HALF_LSB =
    {{(ACC_W + 1 - RF){1'b0}}, 1'b1, {(RF - 1){1'b0}}};

  logic signed [ROT_W-1:0]  rot [3][3];
  logic signed [CW-1:0]     org [3];

  logic                     valid1_q, valid2_q, valid3_q;
  logic signed [REL_W-1:0]  rel1_q [3];
  logic signed [CW-1:0]     dir1_q [3];
  logic [CW-2:0]            max1_q, max2_q, max3_q;
  logic signed [PROD_W-1:0] pp2_q [3][3];
  logic signed [PROD_W-1:0] pd2_q [3][3];
  logic signed [L_W-1:0]    lp3_q [3], ld3_q [3];
  logic signed [L_W-1:0]    lp_d [3], ld_d [3];

  // unpack rotation entries and origin
  always_comb begin
    logic [FZ_W-1:0] fz;
    fz = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        fz = FZ_W'(rot_row_i[r][c*CW +: CW]);
        rot[r][c] = signed'(fz[ROT_W-1:0]);
      end
      org[r] = signed'(origin_i[r*CW +: CW]);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  // stage 1: start relative to box centre
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      rel1_q[r] <= REL_W'(start_i[r]) - REL_W'(org[r]);
      dir1_q[r] <= dir_i[r];
    end
    max1_q <= max_t_i;
  end

  // stage 2: products with transposed rotation
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int r = 0; r < 3; r++) begin
        pp2_q[i][r] <= PROD_W'(rot[r][i]) * PROD_W'(rel1_q[r]);
        pd2_q[i][r] <= PROD_W'(rot[r][i]) * PROD_W'(dir1_q[r]);
      end
    end
    max2_q <= max1_q;
  end

  // stage 3: sums, round half up to coordinate format
  always_comb begin
    logic signed [ACC_W:0] sp;
    logic signed [ACC_W:0] sd;
    sp = '0;
    sd = '0;
    for (int i = 0; i < 3; i++) begin
      sp = (ACC_W+1)'(pp2_q[i][0]) + (ACC_W+1)'(pp2_q[i][1])
         + (ACC_W+1)'(pp2_q[i][2]) + HALF_LSB;
      sd = (ACC_W+1)'(pd2_q[i][0]) + (ACC_W+1)'(pd2_q[i][1])
         + (ACC_W+1)'(pd2_q[i][2]) + HALF_LSB;
      lp_d[i] = signed'(sp[ACC_W:RF]);
      ld_d[i] = signed'(sd[ACC_W:RF]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      lp3_q[i] <= lp_d[i];
      ld3_q[i] <= ld_d[i];
    end
    max3_q <= max2_q;
  end

  assign valid_o = valid3_q;
  assign lp_o    = lp3_q;
  assign ld_o    = ld3_q;
  assign max_t_o = max3_q;

endmodule

`default_nettype wire

/* src/obb_div.sv */
// ----------------------------------------------------------------------------
// obb_div
// Pipelined restoring divider, one quotient bit per stage, saturating
// quotient, truncation toward zero folded to the range -1 .. 2^Q_W.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_div #(
  parameter int unsigned NUM_W = 35,
  parameter int unsigned DEN_W = 26,
  parameter int unsigned Q_W   = 19
) (
  input  logic                clk_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]    den_i,
  input  logic                neg_i,
  output logic signed [Q_W+1:0] t_o
);

  localparam int unsigned CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [CMP_W-1:0] rem_q [Q_W+1];
  logic [Q_W-1:0]   quo_q [Q_W+1];
  logic [DEN_W-1:0] den_q [Q_W+1];
  logic             sat_q [Q_W+1];
  logic             neg_q [Q_W+1];
  logic [Q_W:0]     mag;

  // stage 0: overflow test against the largest useful quotient
  always_ff @(posedge clk_i) begin
    rem_q[0] <= CMP_W'(num_i);
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    sat_q[0] <= CMP_W'(num_i) >= (CMP_W'(den_i) << Q_W);
    neg_q[0] <= neg_i;
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= Q_W; k++) begin : g_bit
    localparam int unsigned B = Q_W - k;
    logic [CMP_W-1:0] shd;
    logic             ge;
    logic [Q_W-1:0]   quo_d;

    always_comb begin
      shd   = CMP_W'(den_q[k-1]) << B;
      ge    = rem_q[k-1] >= shd;
      quo_d = quo_q[k-1];
      quo_d[B] = ge;
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? rem_q[k-1] - shd : rem_q[k-1];
      quo_q[k] <= quo_d;
      den_q[k] <= den_q[k-1];
      sat_q[k] <= sat_q[k-1];
      neg_q[k] <= neg_q[k-1];
    end
  end

  // sign and saturation
  always_comb begin
    mag = sat_q[Q_W] ? {1'b1, {Q_W{1'b0}}} : {1'b0, quo_q[Q_W]};
    if (neg_q[Q_W]) begin
      t_o = (mag != '0) ? '1 : '0;
    end else begin
      t_o = signed'({1'b0, mag});
    end
  end

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the oriented box ray intersector: rays are driven through the command
// port under several box setups and every result is compared with a predicted
// hit flag, entry parameter and entry normal, in order of transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import obb_pkg::*;

  typedef struct packed {
    logic signed [19:0] sx, sy, sz;
    logic signed [19:0] dx, dy, dz;
    logic        [18:0] max_t;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic        [18:0] entry_t;
    logic signed [18:0] nx, ny, nz;
  } slab_hit_t;

  // keeps the box setup, predicts each ray's outcome and checks results
  class slab_scoreboard;
    logic [59:0] regs [5];
    slab_hit_t   pending_hits [$];
    int          fails;

    function new();
      for (int i = 0; i < 5; i++) regs[i] = '0;
      fails = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [59:0] v);
      regs[idx] = v;
    endfunction

    function longint rnd_coord(longint acc);
      return (acc + (64'sd1 <<< 17)) >>> 18;
    endfunction

    // box-space transform, slab clipping and entry normal
    function void note_ray(ray_t r);
      longint    rot [3][3];
      longint    rel [3], wdir [3], ext [3], lp [3], ld [3];
      longint    tmin, tmax, ap, ad, e, t0, t1, n;
      int        axis, sgn, s;
      bit        ok;
      slab_hit_t res;
      tmin = 0; axis = -1; sgn = 1; ok = 1;
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++)
          rot[i][c] = longint'($signed(regs[REG_ROT_ROW0 + i][20*c +: 20]));
        ext[i] = longint'(regs[REG_HALF_EXTENTS][20*i +: 20]);
      end
      rel[0] = longint'(r.sx) - longint'($signed(regs[REG_BOX_ORIGIN][19:0]));
      rel[1] = longint'(r.sy) - longint'($signed(regs[REG_BOX_ORIGIN][39:20]));
      rel[2] = longint'(r.sz) - longint'($signed(regs[REG_BOX_ORIGIN][59:40]));
      wdir[0] = r.dx; wdir[1] = r.dy; wdir[2] = r.dz;
      tmax = longint'(r.max_t);
      for (int i = 0; i < 3; i++) begin
        ap = 0; ad = 0;
        for (int k = 0; k < 3; k++) begin
          ap += rot[k][i] * rel[k];
          ad += rot[k][i] * wdir[k];
        end
        lp[i] = rnd_coord(ap);
        ld[i] = rnd_coord(ad);
      end
      for (int i = 0; i < 3 && ok; i++) begin
        if (ld[i] == 0) begin
          // parallel to the slab: reject when outside it
          if (lp[i] < -ext[i] || lp[i] > ext[i]) ok = 0;
        end else begin
          s  = ld[i] > 0 ? 1 : -1;
          e  = s > 0 ? ext[i] : -ext[i];
          t0 = (-(e + lp[i]) * 256) / ld[i];
          t1 = ((e - lp[i]) * 256) / ld[i];
          if (t0 > tmin) begin
            tmin = t0; axis = i; sgn = s;
          end
          if (t1 < tmax) tmax = t1;
          if (tmin > tmax) ok = 0;
        end
      end
      res = '0;
      res.hit = ok;
      if (ok) begin
        res.entry_t = tmin < 0 ? 19'd0 : (tmin > 524287 ? 19'h7ffff : tmin[18:0]);
        if (axis >= 0) begin
          for (int k = 0; k < 3; k++) begin
            n = sgn > 0 ? -rot[k][axis] : rot[k][axis];
            if (n > 262143) n = 262143;
            if (n < -262144) n = -262144;
            if (k == 0) res.nx = n[18:0];
            else if (k == 1) res.ny = n[18:0];
            else res.nz = n[18:0];
          end
        end
      end
      pending_hits.push_back(res);
    endfunction

    function void check(slab_hit_t got);
      slab_hit_t exp_r;
      if (pending_hits.size() == 0) begin
        $error("result transfer with nothing expected");
        fails++;
        return;
      end
      exp_r = pending_hits.pop_front();
      if (got.hit !== exp_r.hit) begin
        $error("hit: expected %0d actual %0d", exp_r.hit, got.hit); fails++;
      end
      if (got.entry_t !== exp_r.entry_t) begin
        $error("entry_t: expected %0d actual %0d", exp_r.entry_t, got.entry_t); fails++;
      end
      if (got.nx !== exp_r.nx) begin
        $error("normal_x: expected %0d actual %0d", exp_r.nx, got.nx); fails++;
      end
      if (got.ny !== exp_r.ny) begin
        $error("normal_y: expected %0d actual %0d", exp_r.ny, got.ny); fails++;
      end
      if (got.nz !== exp_r.nz) begin
        $error("normal_z: expected %0d actual %0d", exp_r.nz, got.nz); fails++;
      end
    endfunction
  endclass

  localparam int ONE = 262144;  // 1.0 in Q2.18

  logic clk_i, rst_ni, start_i, busy_o, done_o, hit_o, cfg_we_i;
  logic signed [19:0] start_x_i, start_y_i, start_z_i, dir_x_i, dir_y_i, dir_z_i;
  logic        [18:0] max_t_i, entry_t_o;
  logic signed [18:0] normal_x_o, normal_y_o, normal_z_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [59:0]          cfg_wdata_i;

  slab_scoreboard sb = new();
  int     cycles;
  logic [59:0] org;
  bit     busy_mode;

  obb_ray_slab_intersect u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .start_x_i, .start_y_i, .start_z_i, .dir_x_i, .dir_y_i, .dir_z_i, .max_t_i,
    .done_o, .hit_o, .entry_t_o, .normal_x_o, .normal_y_o, .normal_z_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // transfer monitor on both sides
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        sb.note_ray('{start_x_i, start_y_i, start_z_i, dir_x_i, dir_y_i, dir_z_i, max_t_i});
      if (done_o)
        sb.check('{hit_o, entry_t_o, normal_x_o, normal_y_o, normal_z_o});
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [59:0] pack3(int a, int b, int c);
    logic [19:0] fa, fb, fc;
    fa = 20'(a); fb = 20'(b); fc = 20'(c);
    return {fc, fb, fa};
  endfunction

  // one ray transfer, then the sender's own gap
  task automatic send_ray(ray_t r);
    int gap;
    start_i   <= 1'b1;
    start_x_i <= r.sx; start_y_i <= r.sy; start_z_i <= r.sz;
    dir_x_i   <= r.dx; dir_y_i   <= r.dy; dir_z_i   <= r.dz;
    max_t_i   <= r.max_t;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    gap = busy_mode ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending and let the pipeline empty
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_hits.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_box(logic [59:0] ext, logic [59:0] r0, logic [59:0] r1,
                           logic [59:0] r2, logic [59:0] o);
    logic [59:0] v [5];
    v = '{ext, r0, r1, r2, o};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_reg_e'(i);
      cfg_wdata_i <= v[i];
      sb.set_reg(cfg_reg_e'(i), v[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    org = o;
    @(posedge clk_i);
  endtask

  // mostly rays near the box centre, some zero components, some anything
  function automatic ray_t rand_ray();
    ray_t r;
    int   m;
    m = $urandom_range(0, 9);
    if (m < 2) begin
      r = ray_t'(139'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    end else begin
      r.sx = 20'($signed(org[19:0])  + $signed(20'($urandom_range(0, 8191))) - 4096);
      r.sy = 20'($signed(org[39:20]) + $signed(20'($urandom_range(0, 8191))) - 4096);
      r.sz = 20'($signed(org[59:40]) + $signed(20'($urandom_range(0, 8191))) - 4096);
      r.dx = 20'($urandom_range(0, 4095) - 2048);
      r.dy = 20'($urandom_range(0, 4095) - 2048);
      r.dz = 20'($urandom_range(0, 4095) - 2048);
      if (m == 2) r.dx = 0;
      if (m == 3) begin
        r.dy = 0; r.dz = 0;
      end
      r.max_t = ($urandom_range(0, 3) == 0) ? 19'($urandom) : 19'($urandom_range(0, 8191));
    end
    return r;
  endfunction

  task automatic random_phase(int n, bit hold_once);
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) busy_mode = $urandom_range(0, 2) != 0;
      if (hold_once && i == n / 2) begin
        // sender holds until every result is back
        start_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending_hits.size() > 0) @(posedge clk_i);
      end
      send_ray(rand_ray());
    end
    drain();
  endtask

  initial begin
    cycles = 0; start_i = 0; cfg_we_i = 0; cfg_idx_i = '0; cfg_wdata_i = '0;
    start_x_i = 0; start_y_i = 0; start_z_i = 0;
    dir_x_i = 0; dir_y_i = 0; dir_z_i = 0; max_t_i = 0;
    org = '0; busy_mode = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero box and rotation straight after reset
    random_phase(40, 1'b0);

    // unit rotation, box of half size 4.0 at the origin: directed rays
    write_box(pack3(1024, 1024, 1024), pack3(ONE, 0, 0), pack3(0, ONE, 0),
              pack3(0, 0, ONE), '0);
    busy_mode = 1'b1;
    send_ray('{-2560, 0, 0, 256, 0, 0, 19'h7ffff});      // hit on -x face
    send_ray('{2560, 0, 0, -256, 0, 0, 19'h7ffff});      // hit on +x face
    send_ray('{0, -2560, 0, 0, 256, 0, 19'h7ffff});
    send_ray('{0, 0, 2560, 0, 0, -256, 19'h7ffff});
    send_ray('{0, 0, 0, 256, 256, 256, 1000});           // starts inside
    send_ray('{-2560, 0, 0, 256, 0, 0, 100});            // max_t too short
    send_ray('{-2560, 0, 0, 256, 0, 0, 0});              // zero interval
    send_ray('{-2560, 2000, 0, 256, 0, 0, 19'h7ffff});   // parallel, outside
    send_ray('{-2560, 1024, 0, 256, 0, 0, 19'h7ffff});   // parallel, on face
    send_ray('{0, 0, 0, 0, 0, 0, 19'h7ffff});            // zero direction inside
    send_ray('{2560, 0, 0, 0, 0, 0, 0});                 // zero direction outside
    send_ray('{-524288, -524288, -524288, 524287, 524287, 524287, 19'h7ffff});
    send_ray('{524287, 524287, 524287, -524288, -524288, -524288, 19'h7ffff});
    send_ray('{-524288, 0, 0, 1, 0, 0, 19'h7ffff});
    send_ray('{-2560, -2560, -2560, 1, 1, 1, 19'h7ffff});
    send_ray('{2560, 0, 0, 256, 0, 0, 19'h7ffff});       // pointing away
    send_ray('{-1030, 0, 0, 524287, 0, 0, 19'h7ffff});
    drain();
    busy_mode = 1'b0;
    random_phase(100, 1'b1);

    // quarter turn about z, box off centre
    write_box(pack3(512, 2048, 300), pack3(0, -ONE, 0), pack3(ONE, 0, 0),
              pack3(0, 0, ONE), pack3(5000, -3000, 777));
    random_phase(100, 1'b0);

    // extreme rotation entries and largest box
    write_box(60'hfffffffffffffff, pack3(-ONE * 2, ONE * 2 - 1, 0),
              pack3(ONE * 2 - 1, -ONE * 2, 1), pack3(-1, 0, -ONE * 2),
              pack3(-524288, 524287, 0));
    random_phase(80, 1'b0);

    // random setups
    for (int p = 0; p < 3; p++) begin
      write_box({$urandom, $urandom} & 60'h00fff00fff00fff,
                {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom});
      random_phase(100, p == 0);
    end

    if (sb.fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
